// ===== rtl/ptc_pkg.sv =====
`default_nettype none

package ptc_pkg;

  localparam int COG_HARMONIC    = 1;
  localparam int RIPPLE_HARMONIC = 1;
  localparam int ANGLE_BITS      = 16;

  localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [15:0] ANGLE_MASK = 16'hFFFF << ANGLE_DROP;

  localparam logic [19:0] FLUX_MIN = 20'd655;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598670;
  localparam logic [30:0] SIN_C5 = 31'd85569309;
  localparam logic [30:0] SIN_C7 = 31'd5026996;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  localparam int SIN_LAT  = 7;
  localparam int DIV_BITS = 31;
  localparam int MAG_LO   = 14;
  localparam int LAT      = 15 + DIV_BITS;

  localparam logic signed [67:0] NUM_LIMIT = 68'sd35184372088832;

  typedef enum logic [2:0] {
    REG_POLE_PAIRS  = 3'd0,
    REG_FLUX        = 3'd1,
    REG_COG_AMP     = 3'd2,
    REG_COG_PHASE   = 3'd3,
    REG_RIPPLE_AMP  = 3'd4,
    REG_RIPPLE_PHASE = 3'd5,
    REG_COMP_GAIN   = 3'd6
  } ptc_reg_e;

  typedef struct packed {
    logic signed [31:0] torque_cmd;
    logic [15:0]        rotor_angle;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] ripple_torque;
    logic signed [31:0] current_cmd;
  } ptc_out_t;

  typedef struct packed {
    logic        vld;
    logic        neg;
    logic        ovf;
    logic [29:0] rem;
    logic [30:0] quo;
    logic [MAG_LO-1:0] mag;
    logic [31:0] rip;
  } ptc_div_t;

  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    logic [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ptc_sine.sv =====
`default_nettype none

module ptc_sine (
  input  wire logic              clk_i,
  input  wire logic [1:0]        quad_i,
  input  wire logic [30:0]       z_i,
  output logic signed [17:0]     sin_o
);

  localparam logic [30:0] COEF [1:4] = '{ptc_pkg::SIN_C7, ptc_pkg::SIN_C5,
                                         ptc_pkg::SIN_C3, ptc_pkg::SIN_C1};

  logic [30:0] z_q  [0:4];
  logic [1:0]  qd_q [0:5];
  logic [30:0] z2_q [0:3];
  logic [30:0] p_q  [1:4];
  logic [31:0] s_q;
  logic [61:0] sq;
  logic [61:0] zp;
  logic [32:0] rnd;
  logic [16:0] mag;

  assign sq = 62'(z_i) * 62'(z_i);

  always_ff @(posedge clk_i) begin
    z_q[0]  <= z_i;
    qd_q[0] <= quad_i;
    z2_q[0] <= sq[60:30];
  end

  for (genvar j = 1; j <= 4; j++) begin : g_horner
    logic [61:0] hp;
    logic [30:0] prev;
    if (j == 1) begin : g_first
      assign prev = ptc_pkg::SIN_C9;
    end else begin : g_next
      assign prev = p_q[j-1];
    end
    assign hp = 62'(z2_q[j-1]) * 62'(prev);
    always_ff @(posedge clk_i) begin
      p_q[j]  <= COEF[j] - hp[60:30];
      z_q[j]  <= z_q[j-1];
      qd_q[j] <= qd_q[j-1];
    end
    if (j < 4) begin : g_z2
      always_ff @(posedge clk_i) begin
        z2_q[j] <= z2_q[j-1];
      end
    end
  end

  assign zp = 62'(z_q[4]) * 62'(p_q[4]);

  always_ff @(posedge clk_i) begin
    s_q     <= zp[61:30];
    qd_q[5] <= qd_q[4];
  end

  assign rnd = (33'(s_q) + 33'd8192) >> 14;
  assign mag = (rnd > 33'd65536) ? 17'd65536 : rnd[16:0];

  always_ff @(posedge clk_i) begin
    sin_o <= qd_q[5][1] ? -$signed(18'(mag)) : $signed(18'(mag));
  end

endmodule

`default_nettype wire

// ===== rtl/ptc_div_cell.sv =====
`default_nettype none

module ptc_div_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptc_pkg::ptc_div_t cell_i,
  input  wire logic              bit_i,
  input  wire logic [28:0]       den_i,
  output ptc_pkg::ptc_div_t      cell_o
);

  ptc_pkg::ptc_div_t cell_d;
  logic [29:0] r2;
  logic        ge;

  assign r2 = {cell_i.rem[28:0], bit_i};
  assign ge = r2 >= 30'(den_i);

  always_comb begin
    cell_d     = cell_i;
    cell_d.rem = ge ? (r2 - 30'(den_i)) : r2;
    cell_d.quo = {cell_i.quo[29:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else begin
      cell_o <= cell_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmsm_torque_to_current_ripple_comp_top.sv =====
// Channel  | Ports                           | Beat
// ---------+---------------------------------+-----------------------------
// input    | start_i, busy_o, in_i           | start_i & !busy_o
// result   | done_o, res_o                   | done_o, one cycle, no stall
// config   | cfg_we_i, cfg_idx_i, cfg_data_i | cfg_we_i
//
// One beat accepted every cycle; busy_o stays low.
// Result path: 2 entry stages, 7-stage sine, 5 multiply/sum stages,
// 31 restoring-divider cells (one quotient bit each), out reg.
// Reset clears config to defaults and all valid bits.
// Results cannot be held off by the receiver.
`default_nettype none

module pmsm_torque_to_current_ripple_comp_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire ptc_pkg::ptc_in_t in_i,
  output logic                  done_o,
  output ptc_pkg::ptc_out_t     res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i
);

  logic [6:0]         pp_q;
  logic [19:0]        flux_q;
  logic signed [31:0] ca_q;
  logic [15:0]        cph_q;
  logic signed [31:0] ra_q;
  logic [15:0]        rph_q;
  logic signed [31:0] gain_q;
  logic [28:0]        den_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= 7'd1;
      flux_q <= ptc_pkg::FLUX_MIN;
      ca_q   <= '0;
      cph_q  <= '0;
      ra_q   <= '0;
      rph_q  <= '0;
      gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptc_pkg::REG_POLE_PAIRS:   pp_q   <= cfg_data_i[6:0];
        ptc_pkg::REG_FLUX:         flux_q <= cfg_data_i[19:0];
        ptc_pkg::REG_COG_AMP:      ca_q   <= $signed(cfg_data_i);
        ptc_pkg::REG_COG_PHASE:    cph_q  <= cfg_data_i[15:0];
        ptc_pkg::REG_RIPPLE_AMP:   ra_q   <= $signed(cfg_data_i);
        ptc_pkg::REG_RIPPLE_PHASE: rph_q  <= cfg_data_i[15:0];
        ptc_pkg::REG_COMP_GAIN:    gain_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [6:0]  pe;
  logic [19:0] fe;
  assign pe = (pp_q == 7'd0) ? 7'd1 : pp_q;
  assign fe = (flux_q < ptc_pkg::FLUX_MIN) ? ptc_pkg::FLUX_MIN : flux_q;

  always_ff @(posedge clk_i) begin
    den_q <= 29'(pe) * 29'(fe) * 29'd3;
  end

  // entry
  logic               v0_q;
  logic signed [31:0] tq0_q;
  logic [15:0]        ang0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    tq0_q  <= in_i.torque_cmd;
    ang0_q <= in_i.rotor_angle;
  end

  // electrical angles, fold to quarter wave
  logic [15:0] ec, er;
  logic [29:0] zc_raw, zr_raw;
  logic [30:0] zc, zr;
  logic [1:0]  qc_q, qr_q;
  logic [30:0] zc_q, zr_q;
  logic signed [63:0] trp;

  assign ec = (ang0_q * 16'(ptc_pkg::COG_HARMONIC) * 16'(pe) + cph_q) & ptc_pkg::ANGLE_MASK;
  assign er = (ang0_q * 16'(ptc_pkg::RIPPLE_HARMONIC) * 16'(pe) + rph_q)
              & ptc_pkg::ANGLE_MASK;
  assign zc_raw = {ec[13:0], 16'b0};
  assign zr_raw = {er[13:0], 16'b0};
  assign zc = ec[14] ? (31'h4000_0000 - 31'(zc_raw)) : 31'(zc_raw);
  assign zr = er[14] ? (31'h4000_0000 - 31'(zr_raw)) : 31'(zr_raw);
  assign trp = tq0_q * ra_q;

  logic               dv_q  [0:7];
  logic signed [31:0] dtq_q [0:7];
  logic signed [47:0] dtr_q [0:7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) dv_q[k] <= 1'b0;
    end else begin
      dv_q[0] <= v0_q;
      for (int k = 1; k < 8; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    qc_q     <= ec[15:14];
    qr_q     <= er[15:14];
    zc_q     <= zc;
    zr_q     <= zr;
    dtq_q[0] <= tq0_q;
    dtr_q[0] <= $signed(trp[63:16]);
    for (int k = 1; k < 8; k++) begin
      dtq_q[k] <= dtq_q[k-1];
      dtr_q[k] <= dtr_q[k-1];
    end
  end

  logic signed [17:0] sc, sr;

  ptc_sine u_sine_cog (
    .clk_i  (clk_i),
    .quad_i (qc_q),
    .z_i    (zc_q),
    .sin_o  (sc)
  );

  ptc_sine u_sine_rip (
    .clk_i  (clk_i),
    .quad_i (qr_q),
    .z_i    (zr_q),
    .sin_o  (sr)
  );

  // products and sums
  logic signed [49:0] pcog;
  logic signed [65:0] pload;
  assign pcog  = ca_q * 50'(sc);
  assign pload = dtr_q[7] * 66'(sr);

  logic               v9_q, v10_q, v11_q, v12_q;
  logic signed [33:0] cog_q;
  logic signed [49:0] load_q;
  logic signed [31:0] tq9_q, tq10_q, tq11_q;
  logic signed [50:0] rip_q;
  logic [31:0]        rs10_q, rs11_q, rs12_q;
  logic signed [66:0] mhi_q;
  logic signed [32:0] mlo_q;
  logic signed [46:0] num_q;

  logic signed [50:0] rip_d;
  logic signed [66:0] mhi;
  logic signed [48:0] mlo;
  logic signed [67:0] num68;
  logic signed [67:0] numc;

  assign rip_d = 51'(cog_q) + 51'(load_q);
  assign mhi   = gain_q * 67'($signed(rip_q[50:16]));
  assign mlo   = gain_q * 49'($signed({1'b0, rip_q[15:0]}));
  assign num68 = 68'(tq11_q) + 68'(mhi_q) + 68'(mlo_q);
  assign numc  = (num68 > ptc_pkg::NUM_LIMIT) ? ptc_pkg::NUM_LIMIT :
                 (num68 < -ptc_pkg::NUM_LIMIT) ? -ptc_pkg::NUM_LIMIT : num68;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else begin
      v9_q  <= dv_q[7];
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cog_q  <= pcog[49:16];
    load_q <= pload[65:16];
    tq9_q  <= dtq_q[7];
    rip_q  <= rip_d;
    rs10_q <= ptc_pkg::sat32(rip_d);
    tq10_q <= tq9_q;
    mhi_q  <= mhi;
    mlo_q  <= mlo[48:16];
    tq11_q <= tq10_q;
    rs11_q <= rs10_q;
    num_q  <= numc[46:0];
    rs12_q <= rs11_q;
  end

  // divider setup
  ptc_pkg::ptc_div_t d13_q;
  logic [45:0] mag;
  assign mag = num_q[46] ? 46'(-num_q) : num_q[45:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d13_q <= '0;
    end else begin
      d13_q.vld <= v12_q;
      d13_q.neg <= num_q[46];
      d13_q.ovf <= mag[45:14] >= 32'(den_q);
      d13_q.rem <= mag[43:14];
      d13_q.quo <= '0;
      d13_q.mag <= mag[13:0];
      d13_q.rip <= rs12_q;
    end
  end

  ptc_pkg::ptc_div_t cell_q [0:ptc_pkg::DIV_BITS-1];

  for (genvar k = 0; k < ptc_pkg::DIV_BITS; k++) begin : g_cell
    ptc_pkg::ptc_div_t cin;
    logic              b;
    if (k == 0) begin : g_head
      assign cin = d13_q;
    end else begin : g_link
      assign cin = cell_q[k-1];
    end
    if (k < ptc_pkg::MAG_LO) begin : g_bit
      assign b = cin.mag[ptc_pkg::MAG_LO-1-k];
    end else begin : g_zero
      assign b = 1'b0;
    end
    ptc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (cin),
      .bit_i  (b),
      .den_i  (den_q),
      .cell_o (cell_q[k])
    );
  end

  ptc_pkg::ptc_div_t co;
  logic [31:0] cur;
  assign co  = cell_q[ptc_pkg::DIV_BITS-1];
  assign cur = co.ovf ? (co.neg ? 32'h8000_0000 : 32'h7FFF_FFFF) :
               co.neg ? (32'd0 - {1'b0, co.quo}) : {1'b0, co.quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= co.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.ripple_torque <= $signed(co.rip);
    res_o.current_cmd   <= $signed(cur);
  end

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, ptc_pkg::LAT))
    else $error("result beat without matching input beat");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(ptc_pkg::LAT) done_o)
    else $error("input beat produced no result");

  a_cell_vld_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d13_q.vld |-> ##(ptc_pkg::DIV_BITS) co.vld)
    else $error("divider chain lost a beat");

endmodule

`default_nettype wire

// ===== tb/ptc_checker.sv =====
`default_nettype none

module ptc_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire ptc_pkg::ptc_in_t in_i,
  input  wire logic             done_i,
  input  wire ptc_pkg::ptc_out_t res_i,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  logic [6:0]         pole_pairs;
  logic [19:0]        flux;
  logic signed [31:0] cog_amp;
  logic [15:0]        cog_phase;
  logic signed [31:0] rip_amp;
  logic [15:0]        rip_phase;
  logic signed [31:0] gain;

  ptc_out_t expected_q[$];

  function automatic longint sine_q16(input logic [15:0] e);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] s;
    z = {34'd0, e[13:0], 16'd0};
    if (e[14]) z = 64'h4000_0000 - z;
    z2 = (z * z) >> 30;
    p  = 64'(SIN_C9);
    p  = 64'(SIN_C7) - ((z2 * p) >> 30);
    p  = 64'(SIN_C5) - ((z2 * p) >> 30);
    p  = 64'(SIN_C3) - ((z2 * p) >> 30);
    p  = 64'(SIN_C1) - ((z2 * p) >> 30);
    s  = (z * p) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return e[15] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic ptc_out_t compensate(input ptc_in_t x);
    ptc_out_t   r;
    int unsigned p;
    int unsigned fl;
    logic [15:0] ec;
    logic [15:0] er;
    longint      trq;
    longint      sc;
    longint      sr;
    longint      ripple;
    longint      num;
    longint      den;
    p   = (pole_pairs == 0) ? 1 : pole_pairs;
    fl  = (flux < FLUX_MIN) ? FLUX_MIN : flux;
    ec  = 16'(x.rotor_angle * COG_HARMONIC * p + cog_phase) & ANGLE_MASK;
    er  = 16'(x.rotor_angle * RIPPLE_HARMONIC * p + rip_phase) & ANGLE_MASK;
    sc  = sine_q16(ec);
    sr  = sine_q16(er);
    trq = x.torque_cmd;
    ripple = ((longint'(cog_amp) * sc) >>> 16)
           + ((((trq * longint'(rip_amp)) >>> 16) * sr) >>> 16);
    num = trq + longint'(gain) * (ripple >>> 16)
        + ((longint'(gain) * (ripple - ((ripple >>> 16) <<< 16))) >>> 16);
    if (num > (64'sd1 <<< 45)) num = 64'sd1 <<< 45;
    if (num < -(64'sd1 <<< 45)) num = -(64'sd1 <<< 45);
    den = 3 * longint'(p) * longint'(fl);
    r.ripple_torque = clip32(ripple);
    r.current_cmd   = clip32((num * 131072) / den);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs <= 7'd1;
      flux       <= FLUX_MIN;
      cog_amp    <= '0;
      cog_phase  <= '0;
      rip_amp    <= '0;
      rip_phase  <= '0;
      gain       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLE_PAIRS:   pole_pairs <= cfg_data_i[6:0];
        REG_FLUX:         flux       <= cfg_data_i[19:0];
        REG_COG_AMP:      cog_amp    <= cfg_data_i;
        REG_COG_PHASE:    cog_phase  <= cfg_data_i[15:0];
        REG_RIPPLE_AMP:   rip_amp    <= cfg_data_i;
        REG_RIPPLE_PHASE: rip_phase  <= cfg_data_i[15:0];
        REG_COMP_GAIN:    gain       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    ptc_out_t exp_r;
    if (!rst_ni) begin
      errors_o  = 0;
      results_o = 0;
      expected_q.delete();
    end else begin
      if (done_i) begin
        results_o = results_o + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %h", res_i);
          errors_o = errors_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (res_i.ripple_torque !== exp_r.ripple_torque) begin
            $error("ripple_torque expected %0d actual %0d",
                   exp_r.ripple_torque, res_i.ripple_torque);
            errors_o = errors_o + 1;
          end
          if (res_i.current_cmd !== exp_r.current_cmd) begin
            $error("current_cmd expected %0d actual %0d",
                   exp_r.current_cmd, res_i.current_cmd);
            errors_o = errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(compensate(in_i));
    end
    pending_o = expected_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  ptc_in_t     in_i = '0;
  logic        done_o;
  ptc_out_t    res_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          errors;
  int          pending;
  int          results;
  int          idle_pct;
  int          beats_sent;

  always #10 clk_i = ~clk_i;

  pmsm_torque_to_current_ripple_comp_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ptc_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .done_i(done_o), .res_i(res_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  task automatic send(input logic [31:0] trq, input logic [15:0] ang);
    start_i <= 1'b1;
    in_i    <= '{torque_cmd: trq, rotor_angle: ang};
    do @(posedge clk_i); while (busy_o);
    beats_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input ptc_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] pp, input logic [31:0] fl,
                           input logic [31:0] ca, input logic [31:0] cp,
                           input logic [31:0] ra, input logic [31:0] rp,
                           input logic [31:0] g);
    drain();
    write_reg(REG_POLE_PAIRS, pp);
    write_reg(REG_FLUX, fl);
    write_reg(REG_COG_AMP, ca);
    write_reg(REG_COG_PHASE, cp);
    write_reg(REG_RIPPLE_AMP, ra);
    write_reg(REG_RIPPLE_PHASE, rp);
    write_reg(REG_COMP_GAIN, g);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_amp();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_torque();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  initial begin
    logic [31:0] pp;
    logic [31:0] fl;
    idle_pct   = 17;
    beats_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(32'h0001_0000, 16'h0000);
    send(32'h7FFF_FFFF, 16'h4000);
    send(32'h8000_0000, 16'hFFFF);

    write_all(0, 0, 32'h7FFF_FFFF, 16'h0000, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= 32'hFFFF_FFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    for (int b = 0; b < 16; b++) send(32'h7FFF_FFFF, 16'(1 << b));
    send(32'h8000_0000, 16'h8000);
    send(32'h0000_0000, 16'hC000);
    send(32'hFFFF_FFFF, 16'h0000);

    write_all(127, 32'h000F_FFFF, 32'h8000_0000, 16'h4000, 32'h7FFF_FFFF, 16'h8000,
              32'h8000_0000);
    send(32'h7FFF_FFFF, 16'h1234);
    send(32'h8000_0000, 16'hFFFF);
    send(32'h0003_0000, 16'h0000);

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 17 : (ph < 8) ? 64 : 0;
      case ($urandom_range(3))
        0: pp = $urandom_range(1) ? 1 : 64;
        1: pp = $urandom_range(0, 127);
        default: pp = $urandom_range(1, 8);
      endcase
      case ($urandom_range(3))
        0: fl = $urandom_range(0, 655);
        1: fl = 32'h000F_FFFF;
        default: fl = $urandom_range(655, 1 << 18);
      endcase
      write_all(pp, fl, rand_amp(), $urandom_range(0, 65535), rand_amp(),
                $urandom_range(0, 65535), rand_amp());
      repeat (80) send(rand_torque(), $urandom_range(0, 65535));
    end

    drain();
    repeat (LAT + 4) @(posedge clk_i);
    $display("Sent %0d beats over 14 register settings, %0d results checked,", beats_sent,
             results);
    $display("covering torque/amplitude extremes, clamped flux and pole pairs, all angles.");
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== pmsm_torque_to_current_ripple_comp_top.f =====
rtl/ptc_pkg.sv
rtl/ptc_sine.sv
rtl/ptc_div_cell.sv
rtl/pmsm_torque_to_current_ripple_comp_top.sv
tb/ptc_checker.sv
tb/tb.sv
